// ----- design/mrf_pkg.sv -----
// Package with the shared types, codes and the CRC step of the Modbus RTU master framer.
package mrf_pkg;

   // Limits of the protocol and of the response buffer.
   localparam int MAX_READ_REGS   = 125;
   localparam int MAX_WRITE_REGS  = 123;
   localparam int RX_BUFFER_BYTES = 256;
   localparam int WRITE_RESP_BYTES = 8;

   // Input item modes.
   localparam logic [1:0] MODE_CMD  = 2'd0;
   localparam logic [1:0] MODE_DATA = 2'd1;
   localparam logic [1:0] MODE_RXB  = 2'd2;
   localparam logic [1:0] MODE_END  = 2'd3;

   // Command kinds.
   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WSINGLE = 2'd1;
   localparam logic [1:0] OP_WMULTI  = 2'd2;

   // Function codes on the wire.
   localparam logic [7:0] FN_READ    = 8'h03;
   localparam logic [7:0] FN_WSINGLE = 8'h06;
   localparam logic [7:0] FN_WMULTI  = 8'h10;

   // Result kinds and status codes.
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_QTY  = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DATA = 2'd1,
      PH_RESP = 2'd2
   } phase_type;

   // One result transaction.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic [15:0] reg_value;
      logic [1:0]  status;
      logic        last;
   } result_type;

   // One CRC-16 byte update, reflected polynomial.
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- design/mrf_if.sv -----
// Channel interfaces of the Modbus RTU master framer.
interface mrf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [1:0]  op;
   logic [15:0] reg_address;
   logic [15:0] count_or_value;
   logic [15:0] data_word;
   logic [7:0]  rx_byte;
   modport source (output valid, mode, op, reg_address, count_or_value, data_word, rx_byte,
                   input ready);
   modport sink (input valid, mode, op, reg_address, count_or_value, data_word, rx_byte,
                 output ready);
endinterface

interface mrf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  tx_byte;
   logic [15:0] reg_value;
   logic [1:0]  status;
   logic        last;
   modport source (output valid, kind, tx_byte, reg_value, status, last, input ready);
   modport sink (input valid, kind, tx_byte, reg_value, status, last, output ready);
endinterface

interface mrf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ----- design/mrf_out.sv -----
// Output register stage between the framing engine and the result channel.
module mrf_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  mrf_pkg::result_type in_data,
   output logic                in_ready,
   mrf_rsp_if.source           rsp_bus
);
   import mrf_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The register takes a new result when empty or when its result leaves.
   assign in_ready = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
         data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.kind      = data_ff.kind;
   assign rsp_bus.tx_byte   = data_ff.tx_byte;
   assign rsp_bus.reg_value = data_ff.reg_value;
   assign rsp_bus.status    = data_ff.status;
   assign rsp_bus.last      = data_ff.last;
endmodule

// ----- design/mrf_engine.sv -----
// Framing engine: item register, transaction state and result sequencing.
module mrf_engine (
   input  logic                clock,
   input  logic                reset,
   mrf_req_if.sink             req_bus,
   input  logic                csr_valid,
   input  logic [7:0]          csr_data,
   output logic                res_valid,
   output mrf_pkg::result_type res_data,
   input  logic                res_ready
);
   import mrf_pkg::*;

   // Held input item.
   logic        hold_ff, hold_in;
   logic [1:0]  mode_ff, op_ff;
   logic [15:0] addr_ff, cv_ff, dw_ff;
   logic [7:0]  rb_ff;
   logic [2:0]  step_ff, step_in;

   // Transaction state.
   logic [7:0]  slave_ff;
   phase_type   phase_ff, phase_nx;
   logic [1:0]  op_held_ff, op_held_nx;
   logic [15:0] address_held_ff, address_held_nx;
   logic [15:0] count_held_ff, count_held_nx;
   logic [6:0]  words_left_ff, words_left_nx;
   logic [15:0] tx_crc_ff, tx_crc_in;
   logic [15:0] request_crc_ff, request_crc_nx;
   logic [8:0]  rx_count_ff, rx_count_nx;
   logic        header_ok_ff, header_ok_nx;
   logic [7:0]  rx_byte_count_ff, rx_byte_count_nx;
   logic [7:0]  high_hold_ff, high_hold_nx;
   logic [6:0]  value_index_ff, value_index_nx;

   logic [3:0]  n_res;
   logic        data_byte;
   logic        crc_fresh;
   logic        issue, done;
   logic [7:0]  want;
   logic [6:0]  wl_dec;
   logic        ok;
   logic        start_rx;

   // Result list of the held item and the state it leaves behind.
   always_comb begin
      n_res            = 4'd0;
      res_data         = '0;
      data_byte        = 1'b0;
      crc_fresh        = 1'b0;
      start_rx         = 1'b0;
      want             = 8'd0;
      ok               = 1'b0;
      wl_dec           = words_left_ff - 7'd1;
      phase_nx         = phase_ff;
      op_held_nx       = op_held_ff;
      address_held_nx  = address_held_ff;
      count_held_nx    = count_held_ff;
      words_left_nx    = words_left_ff;
      request_crc_nx   = request_crc_ff;
      rx_count_nx      = rx_count_ff;
      header_ok_nx     = header_ok_ff;
      rx_byte_count_nx = rx_byte_count_ff;
      high_hold_nx     = high_hold_ff;
      value_index_nx   = value_index_ff;
      case (mode_ff)
         MODE_CMD: begin
            if (op_ff != 2'd3) begin
               if ((op_ff == OP_READ && (cv_ff == 16'd0 || cv_ff > 16'(MAX_READ_REGS))) ||
                   (op_ff == OP_WMULTI && (cv_ff == 16'd0 ||
                                           cv_ff > 16'(MAX_WRITE_REGS)))) begin
                  n_res           = 4'd1;
                  res_data.kind   = KIND_STATUS;
                  res_data.status = ST_QTY;
                  phase_nx        = PH_IDLE;
               end else begin
                  n_res           = (op_ff == OP_WMULTI) ? 4'd7 : 4'd8;
                  crc_fresh       = (step_ff == 3'd0);
                  res_data.kind   = KIND_TX;
                  op_held_nx      = op_ff;
                  address_held_nx = addr_ff;
                  count_held_nx   = cv_ff;
                  data_byte       = (step_ff < 3'd6) ||
                                    (step_ff == 3'd6 && op_ff == OP_WMULTI);
                  case (step_ff)
                     3'd0: res_data.tx_byte = slave_ff;
                     3'd1: res_data.tx_byte = (op_ff == OP_READ) ? FN_READ :
                                              (op_ff == OP_WSINGLE) ? FN_WSINGLE : FN_WMULTI;
                     3'd2: res_data.tx_byte = addr_ff[15:8];
                     3'd3: res_data.tx_byte = addr_ff[7:0];
                     3'd4: res_data.tx_byte = cv_ff[15:8];
                     3'd5: res_data.tx_byte = cv_ff[7:0];
                     3'd6: res_data.tx_byte = (op_ff == OP_WMULTI) ? {cv_ff[6:0], 1'b0} :
                                              tx_crc_ff[7:0];
                     default: res_data.tx_byte = tx_crc_ff[15:8];
                  endcase
                  if (op_ff == OP_WMULTI) begin
                     words_left_nx = cv_ff[6:0];
                     phase_nx      = PH_DATA;
                  end else begin
                     request_crc_nx = tx_crc_ff;
                     start_rx       = 1'b1;
                  end
               end
            end
         end
         MODE_DATA: begin
            if (phase_ff == PH_DATA) begin
               n_res         = (wl_dec == 7'd0) ? 4'd4 : 4'd2;
               res_data.kind = KIND_TX;
               data_byte     = (step_ff < 3'd2);
               words_left_nx = wl_dec;
               case (step_ff)
                  3'd0: res_data.tx_byte = dw_ff[15:8];
                  3'd1: res_data.tx_byte = dw_ff[7:0];
                  3'd2: res_data.tx_byte = tx_crc_ff[7:0];
                  default: res_data.tx_byte = tx_crc_ff[15:8];
               endcase
               if (wl_dec == 7'd0) begin
                  request_crc_nx = tx_crc_ff;
                  start_rx       = 1'b1;
               end
            end
         end
         MODE_RXB: begin
            if (phase_ff == PH_RESP) begin
               if (op_held_ff == OP_READ) begin
                  if (rx_count_ff < 9'(RX_BUFFER_BYTES)) begin
                     if (rx_count_ff == 9'd0 && rb_ff != slave_ff) header_ok_nx = 1'b0;
                     if (rx_count_ff == 9'd1 && rb_ff != FN_READ) header_ok_nx = 1'b0;
                     if (rx_count_ff == 9'd2) begin
                        rx_byte_count_nx = rb_ff;
                        if (rb_ff != {count_held_ff[6:0], 1'b0}) header_ok_nx = 1'b0;
                     end
                     if (rx_count_ff >= 9'd3 && header_ok_ff &&
                         {9'd0, value_index_ff} < count_held_ff) begin
                        if (rx_count_ff[0]) begin
                           high_hold_nx = rb_ff;
                        end else begin
                           n_res              = 4'd1;
                           res_data.kind      = KIND_VALUE;
                           res_data.reg_value = {high_hold_ff, rb_ff};
                           value_index_nx     = value_index_ff + 7'd1;
                        end
                     end
                     rx_count_nx = rx_count_ff + 9'd1;
                  end
               end else begin
                  if (rx_count_ff < 9'(WRITE_RESP_BYTES)) begin
                     case (rx_count_ff[2:0])
                        3'd0: want = slave_ff;
                        3'd1: want = (op_held_ff == OP_WSINGLE) ? FN_WSINGLE : FN_WMULTI;
                        3'd2: want = address_held_ff[15:8];
                        3'd3: want = address_held_ff[7:0];
                        3'd4: want = count_held_ff[15:8];
                        3'd5: want = count_held_ff[7:0];
                        3'd6: want = (op_held_ff == OP_WSINGLE) ? request_crc_ff[7:0] : rb_ff;
                        default: want = (op_held_ff == OP_WSINGLE) ? request_crc_ff[15:8] :
                                        rb_ff;
                     endcase
                     if (rb_ff != want) header_ok_nx = 1'b0;
                     rx_count_nx = rx_count_ff + 9'd1;
                  end
               end
            end
         end
         default: begin
            if (phase_ff == PH_RESP) begin
               if (op_held_ff == OP_READ) begin
                  ok = header_ok_ff && rx_count_ff >= 9'd5 &&
                       {1'b0, rx_count_ff} >= 10'd5 + {2'd0, rx_byte_count_ff};
               end else begin
                  ok = header_ok_ff && rx_count_ff == 9'(WRITE_RESP_BYTES);
               end
               n_res           = 4'd1;
               res_data.kind   = KIND_STATUS;
               res_data.status = ok ? ST_OK : ST_FAIL;
               phase_nx        = PH_IDLE;
            end else if (phase_ff == PH_DATA) begin
               n_res           = 4'd1;
               res_data.kind   = KIND_STATUS;
               res_data.status = ST_FAIL;
               phase_nx        = PH_IDLE;
            end
         end
      endcase
      if (start_rx) begin
         phase_nx         = PH_RESP;
         rx_count_nx      = 9'd0;
         header_ok_nx     = 1'b1;
         rx_byte_count_nx = 8'd0;
         high_hold_nx     = 8'd0;
         value_index_nx   = 7'd0;
      end
      res_data.last = ({1'b0, step_ff} == n_res - 4'd1);
   end

   // One result per cycle while the output stage has room.
   assign res_valid     = hold_ff && n_res != 4'd0;
   assign issue         = res_valid && res_ready;
   assign done          = hold_ff && (n_res == 4'd0 || (issue && res_data.last));
   assign req_bus.ready = !hold_ff || done;

   always_comb begin
      hold_in = hold_ff;
      step_in = step_ff;
      if (issue) step_in = step_ff + 3'd1;
      if (done) begin
         hold_in = 1'b0;
         step_in = 3'd0;
      end
      if (req_bus.valid && req_bus.ready) hold_in = 1'b1;
   end

   // Running request CRC, folded one sent byte at a time.
   always_comb begin
      tx_crc_in = tx_crc_ff;
      if (issue && data_byte) begin
         tx_crc_in = crc_step(crc_fresh ? CRC_INIT : tx_crc_ff, res_data.tx_byte);
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff          <= 1'b0;
         step_ff          <= 3'd0;
         slave_ff         <= 8'd1;
         phase_ff         <= PH_IDLE;
         op_held_ff       <= 2'd0;
         address_held_ff  <= 16'd0;
         count_held_ff    <= 16'd0;
         words_left_ff    <= 7'd0;
         tx_crc_ff        <= CRC_INIT;
         request_crc_ff   <= 16'd0;
         rx_count_ff      <= 9'd0;
         header_ok_ff     <= 1'b0;
         rx_byte_count_ff <= 8'd0;
         high_hold_ff     <= 8'd0;
         value_index_ff   <= 7'd0;
      end else begin
         hold_ff   <= hold_in;
         step_ff   <= step_in;
         tx_crc_ff <= tx_crc_in;
         if (csr_valid) slave_ff <= csr_data;
         if (done) begin
            phase_ff         <= phase_nx;
            op_held_ff       <= op_held_nx;
            address_held_ff  <= address_held_nx;
            count_held_ff    <= count_held_nx;
            words_left_ff    <= words_left_nx;
            request_crc_ff   <= request_crc_nx;
            rx_count_ff      <= rx_count_nx;
            header_ok_ff     <= header_ok_nx;
            rx_byte_count_ff <= rx_byte_count_nx;
            high_hold_ff     <= high_hold_nx;
            value_index_ff   <= value_index_nx;
         end
      end
   end

   // Input item register.
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         mode_ff <= req_bus.mode;
         op_ff   <= req_bus.op;
         addr_ff <= req_bus.reg_address;
         cv_ff   <= req_bus.count_or_value;
         dw_ff   <= req_bus.data_word;
         rb_ff   <= req_bus.rx_byte;
      end
   end
endmodule

// ----- design/modbus_rtu_master_framer.sv -----
// Top level of the Modbus RTU master framer: framing engine and output register.
// The first result passes the item register and then the output register; further results
// follow one per cycle while the output has room. A command gives up to 8 results, sent in
// turn through the single result port of the engine, which serializes the request bytes and folds the CRC.
// An item with no result gives no output; the next item is taken as the last result issues.
// Reset is synchronous and active high; it clears the control and transaction state and sets the slave address to 1.
module modbus_rtu_master_framer (
   input  logic      clock,
   input  logic      reset,
   mrf_req_if.sink   req_bus,
   mrf_rsp_if.source rsp_bus,
   mrf_csr_if.sink   csr_bus
);
   import mrf_pkg::*;

   logic       res_valid, res_ready;
   result_type res_data;

   // The slave address register is always writable.
   assign csr_bus.ready = 1'b1;

   mrf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_valid (csr_bus.valid),
      .csr_data  (csr_bus.data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   mrf_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res_data),
      .in_ready (res_ready),
      .rsp_bus  (rsp_bus)
   );
endmodule

// ----- sim/modbus_rtu_master_framer_tb.sv -----
// Self-checking testbench of the Modbus RTU master framer: directed and random traffic vs. a predictor.
`timescale 1ns / 100ps

module modbus_rtu_master_framer_tb;
   import mrf_pkg::*;

   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  op;
      logic [15:0] reg_address;
      logic [15:0] count_or_value;
      logic [15:0] data_word;
      logic [7:0]  rx_byte;
   } item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrf_req_if req_bus ();
   mrf_rsp_if rsp_bus ();
   mrf_csr_if csr_bus ();

   modbus_rtu_master_framer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   always #2 clock = ~clock;

   // Predictor state.
   logic [7:0]  pr_slave;
   phase_type   pr_phase;
   logic [1:0]  pr_op;
   logic [15:0] pr_addr;
   logic [15:0] pr_count;
   logic [6:0]  pr_words_left;
   logic [15:0] pr_tx_crc;
   logic [15:0] pr_req_crc;
   logic [8:0]  pr_rx_count;
   logic        pr_header_ok;
   logic [7:0]  pr_byte_count;
   logic [7:0]  pr_high;
   logic [6:0]  pr_value_index;

   item_type   pending_items[$];
   result_type expected_results[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   bit cfg_pending = 1'b0;
   logic [7:0] cfg_value;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'd0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic result_type mk(input logic [1:0] kind, input logic [7:0] tx,
                                     input logic [15:0] val, input logic [1:0] st);
      result_type r;
      r.kind = kind; r.tx_byte = tx; r.reg_value = val; r.status = st; r.last = 1'b0;
      return r;
   endfunction

   task automatic emit_byte(inout result_type batch[$], input logic [7:0] b);
      pr_tx_crc = crc_update(pr_tx_crc, b);
      batch.push_back(mk(KIND_TX, b, 16'd0, ST_OK));
   endtask

   task automatic emit_crc_and_listen(inout result_type batch[$]);
      batch.push_back(mk(KIND_TX, pr_tx_crc[7:0], 16'd0, ST_OK));
      batch.push_back(mk(KIND_TX, pr_tx_crc[15:8], 16'd0, ST_OK));
      pr_req_crc = pr_tx_crc;
      pr_phase = PH_RESP;
      pr_rx_count = '0; pr_header_ok = 1'b1; pr_byte_count = '0;
      pr_high = '0; pr_value_index = '0;
   endtask

   task automatic predictor_reset();
      pr_slave = 8'd1; pr_phase = PH_IDLE; pr_op = '0; pr_addr = '0; pr_count = '0;
      pr_words_left = '0; pr_tx_crc = CRC_INIT; pr_req_crc = '0; pr_rx_count = '0;
      pr_header_ok = 1'b0; pr_byte_count = '0; pr_high = '0; pr_value_index = '0;
   endtask

   // Works out the results of one accepted item.
   task automatic predict_item(input item_type it);
      result_type batch[$];
      logic [7:0] want, fn;
      int i;
      logic ok;
      case (it.mode)
         MODE_CMD: if (it.op != 2'd3) begin
            fn = (it.op == OP_READ) ? FN_READ : (it.op == OP_WSINGLE) ? FN_WSINGLE : FN_WMULTI;
            if ((it.op == OP_READ && (it.count_or_value == 0 ||
                 it.count_or_value > MAX_READ_REGS)) ||
                (it.op == OP_WMULTI && (it.count_or_value == 0 ||
                 it.count_or_value > MAX_WRITE_REGS))) begin
               pr_phase = PH_IDLE;
               batch.push_back(mk(KIND_STATUS, 8'd0, 16'd0, ST_QTY));
            end else begin
               pr_op = it.op; pr_addr = it.reg_address; pr_count = it.count_or_value;
               pr_tx_crc = CRC_INIT;
               emit_byte(batch, pr_slave);
               emit_byte(batch, fn);
               emit_byte(batch, it.reg_address[15:8]);
               emit_byte(batch, it.reg_address[7:0]);
               emit_byte(batch, it.count_or_value[15:8]);
               emit_byte(batch, it.count_or_value[7:0]);
               if (it.op == OP_WMULTI) begin
                  emit_byte(batch, {it.count_or_value[6:0], 1'b0});
                  pr_words_left = it.count_or_value[6:0];
                  pr_phase = PH_DATA;
               end else begin
                  emit_crc_and_listen(batch);
               end
            end
         end
         MODE_DATA: if (pr_phase == PH_DATA) begin
            emit_byte(batch, it.data_word[15:8]);
            emit_byte(batch, it.data_word[7:0]);
            pr_words_left = pr_words_left - 7'd1;
            if (pr_words_left == 7'd0) emit_crc_and_listen(batch);
         end
         MODE_RXB: if (pr_phase == PH_RESP) begin
            i = int'(pr_rx_count);
            if (pr_op == OP_READ) begin
               if (i < RX_BUFFER_BYTES) begin
                  if (i == 0 && it.rx_byte != pr_slave) pr_header_ok = 1'b0;
                  if (i == 1 && it.rx_byte != FN_READ) pr_header_ok = 1'b0;
                  if (i == 2) begin
                     pr_byte_count = it.rx_byte;
                     if (it.rx_byte != {pr_count[6:0], 1'b0}) pr_header_ok = 1'b0;
                  end
                  if (i >= 3 && pr_header_ok && {9'd0, pr_value_index} < pr_count) begin
                     if (((i - 3) & 1) == 0) pr_high = it.rx_byte;
                     else begin
                        batch.push_back(mk(KIND_VALUE, 8'd0, {pr_high, it.rx_byte}, ST_OK));
                        pr_value_index = pr_value_index + 7'd1;
                     end
                  end
                  pr_rx_count = 9'(i + 1);
               end
            end else if (i < WRITE_RESP_BYTES) begin
               case (i)
                  0: want = pr_slave;
                  1: want = (pr_op == OP_WSINGLE) ? FN_WSINGLE : FN_WMULTI;
                  2: want = pr_addr[15:8];
                  3: want = pr_addr[7:0];
                  4: want = pr_count[15:8];
                  5: want = pr_count[7:0];
                  6: want = (pr_op == OP_WSINGLE) ? pr_req_crc[7:0] : it.rx_byte;
                  default: want = (pr_op == OP_WSINGLE) ? pr_req_crc[15:8] : it.rx_byte;
               endcase
               if (it.rx_byte != want) pr_header_ok = 1'b0;
               pr_rx_count = 9'(i + 1);
            end
         end
         default: begin
            if (pr_phase == PH_RESP) begin
               if (pr_op == OP_READ)
                  ok = pr_header_ok && int'(pr_rx_count) >= 5 &&
                       int'(pr_rx_count) >= 5 + int'(pr_byte_count);
               else
                  ok = pr_header_ok && int'(pr_rx_count) == WRITE_RESP_BYTES;
               pr_phase = PH_IDLE;
               batch.push_back(mk(KIND_STATUS, 8'd0, 16'd0, ok ? ST_OK : ST_FAIL));
            end else if (pr_phase == PH_DATA) begin
               pr_phase = PH_IDLE;
               batch.push_back(mk(KIND_STATUS, 8'd0, 16'd0, ST_FAIL));
            end
         end
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) expected_results.push_back(batch[k]);
   endtask

   // Driver: sends pending items, with random gaps unless quiet is set.
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_item(pending_items.pop_front());
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_items.size() > 0 && !cfg_pending) begin
               req_bus.valid <= 1'b1;
               req_bus.mode <= pending_items[0].mode;
               req_bus.op <= pending_items[0].op;
               req_bus.reg_address <= pending_items[0].reg_address;
               req_bus.count_or_value <= pending_items[0].count_or_value;
               req_bus.data_word <= pending_items[0].data_word;
               req_bus.rx_byte <= pending_items[0].rx_byte;
               if (!quiet && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 14);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks every result transaction against the oldest expectation.
   int rsp_gap = 0;
   result_type got, want_r;
   always @(posedge clock) begin
      cycles++;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.kind, rsp_bus.tx_byte, rsp_bus.reg_value, rsp_bus.status,
                    rsp_bus.last};
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", got));
            end else begin
               want_r = expected_results.pop_front();
               if (got.kind != want_r.kind)
                  report_mismatch($sformatf("kind %0d want %0d", got.kind, want_r.kind));
               if (got.tx_byte != want_r.tx_byte)
                  report_mismatch($sformatf("tx_byte %h want %h", got.tx_byte, want_r.tx_byte));
               if (got.reg_value != want_r.reg_value)
                  report_mismatch($sformatf("reg_value %h want %h", got.reg_value,
                                            want_r.reg_value));
               if (got.status != want_r.status)
                  report_mismatch($sformatf("status %0d want %0d", got.status, want_r.status));
               if (got.last != want_r.last)
                  report_mismatch($sformatf("last %0d want %0d", got.last, want_r.last));
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(0, 13);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Configuration channel.
   always @(posedge clock) begin
      if (reset) begin
         csr_bus.valid <= 1'b0;
      end else if (csr_bus.valid && csr_bus.ready) begin
         pr_slave = csr_bus.data;
         csr_bus.valid <= 1'b0;
         cfg_pending = 1'b0;
      end else if (cfg_pending) begin
         csr_bus.valid <= 1'b1;
         csr_bus.data <= cfg_value;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("** modbus_rtu_master_framer: FAILED **");
         $finish;
      end
   end

   function automatic item_type mk_item(input logic [1:0] mode, input logic [1:0] op,
                                        input logic [15:0] a, input logic [15:0] cv,
                                        input logic [15:0] dw, input logic [7:0] rb);
      item_type it;
      it.mode = mode; it.op = op; it.reg_address = a; it.count_or_value = cv;
      it.data_word = dw; it.rx_byte = rb;
      return it;
   endfunction

   function automatic item_type noise_fill(input item_type it);
      item_type r;
      r = it;
      if (it.mode != MODE_CMD) begin
         r.op = 2'($urandom); r.reg_address = 16'($urandom);
         r.count_or_value = 16'($urandom);
      end
      if (it.mode != MODE_DATA) r.data_word = 16'($urandom);
      if (it.mode != MODE_RXB) r.rx_byte = 8'($urandom);
      return r;
   endfunction

   task automatic push(input item_type it);
      pending_items.push_back(noise_fill(it));
   endtask

   // Builds one well-formed transaction with an optionally corrupted response.
   task automatic push_transaction(input logic [7:0] slave, input bit bad);
      logic [1:0] op;
      logic [15:0] a, cv, crc;
      logic [7:0] bytes[$];
      int n, nb, pos;
      op = 2'($urandom_range(0, 2));
      a = 16'($urandom);
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 125) : $urandom_range(1, 4);
      if (op == OP_WMULTI && n > 123) n = 123;
      cv = (op == OP_WSINGLE) ? 16'($urandom) : 16'(n);
      push(mk_item(MODE_CMD, op, a, cv, 0, 0));
      if (op == OP_WMULTI) for (int k = 0; k < n; k++) push(mk_item(MODE_DATA, 0, 0, 0,
                                                                  16'($urandom), 0));
      if (op == OP_READ) begin
         bytes.push_back(slave); bytes.push_back(FN_READ); bytes.push_back(8'(2 * n));
         for (int k = 0; k < 2 * n + 2; k++) bytes.push_back(8'($urandom));
      end else begin
         crc = CRC_INIT;
         bytes.push_back(slave);
         bytes.push_back(op == OP_WSINGLE ? FN_WSINGLE : FN_WMULTI);
         bytes.push_back(a[15:8]); bytes.push_back(a[7:0]);
         bytes.push_back(cv[15:8]); bytes.push_back(cv[7:0]);
         foreach (bytes[k]) crc = crc_update(crc, bytes[k]);
         bytes.push_back(crc[7:0]); bytes.push_back(crc[15:8]);
      end
      if (bad) begin
         case ($urandom_range(0, 2))
            0: begin pos = $urandom_range(0, bytes.size() - 1);
                     bytes[pos] = bytes[pos] ^ 8'(1 << $urandom_range(0, 7)); end
            1: begin nb = $urandom_range(0, bytes.size() - 1);
                     while (bytes.size() > nb) void'(bytes.pop_back()); end
            default: for (int k = 0; k < $urandom_range(1, 4); k++)
                        bytes.push_back(8'($urandom));
         endcase
      end
      foreach (bytes[k]) push(mk_item(MODE_RXB, 0, 0, 0, 0, bytes[k]));
      push(mk_item(MODE_END, 0, 0, 0, 0, 0));
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_slave(input logic [7:0] v);
      cfg_value = v;
      cfg_pending = 1'b1;
      while (cfg_pending) @(posedge clock);
      @(posedge clock);
   endtask

   logic [7:0] slaves[4] = '{8'd1, 8'd0, 8'd255, 8'd47};

   initial begin
      predictor_reset();
      req_bus.valid = 1'b0; req_bus.mode = '0; req_bus.op = '0; req_bus.reg_address = '0;
      req_bus.count_or_value = '0; req_bus.data_word = '0; req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0; csr_bus.valid = 1'b0; csr_bus.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: quantity limits, unknown op, misplaced items, abandon.
      push(mk_item(MODE_END, 0, 0, 0, 0, 0));
      push(mk_item(MODE_DATA, 0, 0, 0, 16'hFFFF, 0));
      push(mk_item(MODE_RXB, 0, 0, 0, 0, 8'hFF));
      push(mk_item(MODE_CMD, OP_READ, 16'hFFFF, 16'd0, 0, 0));
      push(mk_item(MODE_CMD, OP_READ, 16'h0000, 16'd126, 0, 0));
      push(mk_item(MODE_CMD, OP_WMULTI, 16'h1234, 16'd124, 0, 0));
      push(mk_item(MODE_CMD, OP_WMULTI, 16'h1234, 16'd0, 0, 0));
      push(mk_item(MODE_CMD, OP_WMULTI, 16'h1234, 16'hFFFF, 0, 0));
      push(mk_item(MODE_CMD, 2'd3, 16'h5555, 16'd3, 0, 0));
      push(mk_item(MODE_CMD, OP_WSINGLE, 16'hFFFF, 16'hFFFF, 0, 0));
      push(mk_item(MODE_CMD, OP_WMULTI, 16'h0000, 16'd2, 0, 0));
      push(mk_item(MODE_DATA, 0, 0, 0, 16'h0000, 0));
      push(mk_item(MODE_END, 0, 0, 0, 0, 0));
      push(mk_item(MODE_CMD, OP_READ, 16'h0001, 16'd125, 0, 0));
      push(mk_item(MODE_CMD, OP_WMULTI, 16'h0002, 16'd123, 0, 0));
      push(mk_item(MODE_CMD, OP_READ, 16'h0003, 16'd1, 0, 0));
      push(mk_item(MODE_RXB, 0, 0, 0, 0, 8'd1));
      push(mk_item(MODE_END, 0, 0, 0, 0, 0));
      push_transaction(8'd1, 1'b0);
      wait_idle();

      // Random phases, each under another slave address.
      for (int ph = 0; ph < 4; ph++) begin
         set_slave(slaves[ph]);
         if (ph == 3) quiet = 1'b1;
         while (pending_items.size() < 110) begin
            if ($urandom_range(0, 9) < 7) push_transaction(slaves[ph], $urandom_range(0, 3) == 0);
            else push(mk_item(2'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 8'($urandom)));
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("** modbus_rtu_master_framer: PASSED **");
      end else begin
         $display("** modbus_rtu_master_framer: FAILED **");
      end
      $finish;
   end

endmodule
